### src/tbpr_pkg.sv
// shared types and constants for the tile background pixel renderer
package tbpr_pkg;

    // default sizes
    localparam int TILE_MEM_BYTES_DEF = 65536;
    localparam int CHAR_COUNT_DEF     = 1024;

    // field widths
    localparam int ACTION_W     = 2;
    localparam int ADDR_W       = 16;
    localparam int DATA_W       = 32;
    localparam int ENTRY_W      = 16;
    localparam int CHAR_FIELD_W = 10;
    localparam int BANK_W       = 4;
    localparam int COORD_W      = 3;
    localparam int PIX_IDX_W    = 6;
    localparam int BYTE_W       = 8;
    localparam int NIB_W        = 4;
    localparam int PAL_IDX_W    = 8;
    localparam int COLOR_W      = 32;
    localparam int OFFSET_W     = 16;
    localparam int SUM_W        = 17;

    // map entry layout
    localparam int HFLIP_POS = 10;
    localparam int VFLIP_POS = 11;
    localparam int BANK_LSB  = 12;

    // transaction codes
    localparam logic [ACTION_W-1:0] ACT_TILE_WR = 2'd0;
    localparam logic [ACTION_W-1:0] ACT_PAL_WR  = 2'd1;
    localparam logic [ACTION_W-1:0] ACT_DRAW    = 2'd2;

    // configuration register indexes
    localparam int CFG_IDX_W = 1;
    localparam int CFG_DATA_W = 16;
    localparam logic [CFG_IDX_W-1:0] CFG_COLOR_MODE = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_CHAR_BASE  = 1'b1;

    // last pixel of a tile
    localparam logic [PIX_IDX_W-1:0] LAST_PIX = 6'd63;

    // input transaction
    typedef struct packed {
        logic [ACTION_W-1:0] action;
        logic [ADDR_W-1:0]   address;
        logic [DATA_W-1:0]   data;
        logic [ENTRY_W-1:0]  map_entry;
    } t_in_item;

    // output transaction
    typedef struct packed {
        logic [COORD_W-1:0] pixel_x;
        logic [COORD_W-1:0] pixel_y;
        logic [COLOR_W-1:0] color;
        logic               last;
    } t_out_item;

    // per-pixel control that travels down the pipeline
    typedef struct packed {
        logic               valid;
        logic [COORD_W-1:0] x;
        logic [COORD_W-1:0] y;
        logic               last;
        logic               nib_hi;
        logic               mode8;
        logic [BANK_W-1:0]  bank;
    } t_pix_ctl;

endpackage

### src/tbpr_seq.sv
// pixel sequencer: walks the 64 pixels of a tile and forms tile byte addresses
module tbpr_seq import tbpr_pkg::*; #(
    parameter int TILE_MEM_BYTES = TILE_MEM_BYTES_DEF,
    parameter int CHAR_COUNT     = CHAR_COUNT_DEF,
    localparam int TILE_AW       = $clog2(TILE_MEM_BYTES),
    localparam int CHAR_W        = $clog2(CHAR_COUNT)
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_draw,
    input  logic [ENTRY_W-1:0]    i_map_entry,
    input  logic                  i_color_mode,
    input  logic [CFG_DATA_W-1:0] i_char_base,
    output logic                  o_run,
    output t_pix_ctl              o_ctl,
    output logic [TILE_AW-1:0]    o_tile_addr
);

    logic                 r_run;
    logic [PIX_IDX_W-1:0] r_cnt;
    logic [CHAR_W-1:0]    r_chr;
    logic                 r_hflip;
    logic                 r_vflip;
    logic [BANK_W-1:0]    r_bank;
    t_pix_ctl             r_ctl;
    logic [TILE_AW-1:0]   r_addr;

    logic [COORD_W-1:0]   n_sx;
    logic [COORD_W-1:0]   n_sy;
    logic [OFFSET_W-1:0]  n_off;
    logic [SUM_W-1:0]     n_sum;
    logic [CHAR_FIELD_W-1:0] n_chr;

    // source column and row after flipping
    always_comb begin
        n_sx  = r_cnt[COORD_W-1:0] ^ {COORD_W{r_hflip}};
        n_sy  = r_cnt[PIX_IDX_W-1:COORD_W] ^ {COORD_W{r_vflip}};
        n_chr = CHAR_FIELD_W'(r_chr);
        if (i_color_mode) begin
            n_off = {n_chr, n_sy, n_sx};
        end else begin
            n_off = {1'b0, n_chr, n_sy, n_sx[COORD_W-1:1]};
        end
        n_sum = {1'b0, i_char_base} + {1'b0, n_off};
    end

    // pixel counter and stage register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_run     <= 1'b0;
            r_cnt     <= '0;
            r_ctl     <= '0;
        end else begin
            if (i_draw) begin
                r_run   <= 1'b1;
                r_cnt   <= '0;
                r_chr   <= i_map_entry[CHAR_W-1:0];
                r_hflip <= i_map_entry[HFLIP_POS];
                r_vflip <= i_map_entry[VFLIP_POS];
                r_bank  <= i_map_entry[BANK_LSB +: BANK_W];
            end else if (r_run) begin
                r_cnt <= r_cnt + 1'b1;
                if (r_cnt == LAST_PIX) begin
                    r_run <= 1'b0;
                end
            end
            r_ctl.valid  <= r_run;
            r_ctl.x      <= r_cnt[COORD_W-1:0];
            r_ctl.y      <= r_cnt[PIX_IDX_W-1:COORD_W];
            r_ctl.last   <= (r_cnt == LAST_PIX);
            r_ctl.nib_hi <= n_sx[0];
            r_ctl.mode8  <= i_color_mode;
            r_ctl.bank   <= r_bank;
            r_addr       <= TILE_AW'(n_sum);
        end
    end

    assign o_run       = r_run;
    assign o_ctl       = r_ctl;
    assign o_tile_addr = r_addr;

endmodule

### src/tbpr_tile_mem.sv
// tile byte memory with write port and registered pixel read
module tbpr_tile_mem import tbpr_pkg::*; #(
    parameter int TILE_MEM_BYTES = TILE_MEM_BYTES_DEF,
    localparam int TILE_AW       = $clog2(TILE_MEM_BYTES)
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_we,
    input  logic [ADDR_W-1:0]  i_waddr,
    input  logic [BYTE_W-1:0]  i_wdata,
    input  t_pix_ctl           i_ctl,
    input  logic [TILE_AW-1:0] i_raddr,
    output t_pix_ctl           o_ctl,
    output logic [BYTE_W-1:0]  o_byte
);

    logic [BYTE_W-1:0] r_mem [TILE_MEM_BYTES];
    logic [BYTE_W-1:0] r_byte;
    t_pix_ctl          r_ctl;

    // memory write and read
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[TILE_AW'(i_waddr)] <= i_wdata;
        end
        r_byte <= r_mem[i_raddr];
    end

    // control follows the read
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ctl <= '0;
        end else begin
            r_ctl <= i_ctl;
        end
    end

    assign o_ctl  = r_ctl;
    assign o_byte = r_byte;

endmodule

### src/tbpr_pal.sv
// palette memory: nibble select, color lookup and output register
module tbpr_pal import tbpr_pkg::*; (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_we,
    input  logic [PAL_IDX_W-1:0] i_waddr,
    input  logic [COLOR_W-1:0]   i_wdata,
    input  t_pix_ctl             i_ctl,
    input  logic [BYTE_W-1:0]    i_byte,
    output logic                 o_valid,
    output t_out_item            o_result
);

    logic [COLOR_W-1:0]   r_mem [1 << PAL_IDX_W];
    logic [COLOR_W-1:0]   r_color;
    logic                 r_valid;
    logic [COORD_W-1:0]   r_x;
    logic [COORD_W-1:0]   r_y;
    logic                 r_last;
    logic [PAL_IDX_W-1:0] n_idx;
    logic [NIB_W-1:0]     n_nib;

    // palette index from the tile byte
    always_comb begin
        n_nib = i_ctl.nib_hi ? i_byte[BYTE_W-1:NIB_W] : i_byte[NIB_W-1:0];
        if (i_ctl.mode8) begin
            n_idx = i_byte;
        end else begin
            n_idx = {i_ctl.bank, n_nib};
        end
    end

    // palette write and color read
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_color <= r_mem[n_idx];
        r_x     <= i_ctl.x;
        r_y     <= i_ctl.y;
        r_last  <= i_ctl.last;
    end

    // result strobe
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= i_ctl.valid;
        end
    end

    assign o_valid          = r_valid;
    assign o_result.pixel_x = r_x;
    assign o_result.pixel_y = r_y;
    assign o_result.color   = r_color;
    assign o_result.last    = r_last;

endmodule

### src/tile_background_pixel_renderer_unit.sv
// top level of the tile background pixel renderer
// A transaction is taken when i_start is high and o_busy is low. Tile byte and
// palette writes leave o_busy low, so they can follow one per cycle. A draw
// transaction raises o_busy while the pixel sequencer steps through the tile
// one pixel a cycle, and until the last pixel has passed the tile memory read
// and palette read stages that follow it. The 64 pixels appear on o_result,
// one per cycle in raster order, marked by o_valid, after the sequencer, tile
// memory read and palette read registers; the last one has last set. The
// receiver cannot stall the output. Configuration writes on i_cfg_we take
// effect at once and must only be made while o_busy is low.
module tile_background_pixel_renderer_unit import tbpr_pkg::*; #(
    parameter int TILE_MEM_BYTES = TILE_MEM_BYTES_DEF,
    parameter int CHAR_COUNT     = CHAR_COUNT_DEF,
    localparam int TILE_AW       = $clog2(TILE_MEM_BYTES)
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_start,
    input  t_in_item              i_item,
    output logic                  o_busy,
    output logic                  o_valid,
    output t_out_item             o_result,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_data
);

    logic                  r_color_mode;
    logic [CFG_DATA_W-1:0] r_char_base;

    logic               accept;
    logic               draw;
    logic               tile_we;
    logic               pal_we;
    logic               seq_run;
    t_pix_ctl           s0_ctl;
    t_pix_ctl           s1_ctl;
    logic [TILE_AW-1:0] s0_addr;
    logic [BYTE_W-1:0]  s1_byte;

    // transaction decode
    assign accept  = i_start && !o_busy;
    assign draw    = accept && (i_item.action == ACT_DRAW);
    assign tile_we = accept && (i_item.action == ACT_TILE_WR);
    assign pal_we  = accept && (i_item.action == ACT_PAL_WR);

    // busy until the last pixel has passed the palette read
    assign o_busy = seq_run || s0_ctl.valid || s1_ctl.valid;

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_color_mode <= 1'b0;
            r_char_base  <= '0;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                CFG_COLOR_MODE: r_color_mode <= i_cfg_data[0];
                CFG_CHAR_BASE:  r_char_base  <= i_cfg_data;
                default: ;
            endcase
        end
    end

    tbpr_seq #(
        .TILE_MEM_BYTES (TILE_MEM_BYTES),
        .CHAR_COUNT     (CHAR_COUNT)
    ) u_seq (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_draw       (draw),
        .i_map_entry  (i_item.map_entry),
        .i_color_mode (r_color_mode),
        .i_char_base  (r_char_base),
        .o_run        (seq_run),
        .o_ctl        (s0_ctl),
        .o_tile_addr  (s0_addr)
    );

    tbpr_tile_mem #(
        .TILE_MEM_BYTES (TILE_MEM_BYTES)
    ) u_tile_mem (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_we    (tile_we),
        .i_waddr (i_item.address),
        .i_wdata (i_item.data[BYTE_W-1:0]),
        .i_ctl   (s0_ctl),
        .i_raddr (s0_addr),
        .o_ctl   (s1_ctl),
        .o_byte  (s1_byte)
    );

    tbpr_pal u_pal (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_we     (pal_we),
        .i_waddr  (i_item.address[PAL_IDX_W-1:0]),
        .i_wdata  (i_item.data),
        .i_ctl    (s1_ctl),
        .i_byte   (s1_byte),
        .o_valid  (o_valid),
        .o_result (o_result)
    );

endmodule

### test/tile_background_pixel_renderer_unit_tb.sv
`timescale 1ns / 100ps
// self-checking testbench for the tile background pixel renderer unit
module tile_background_pixel_renderer_unit_tb;
    import tbpr_pkg::*;

    localparam int CLK_HALF      = 6;
    localparam int RESET_CYCLES  = 5;
    // a draw holds busy until its last pixel has passed the palette read
    localparam int SETTLE_CYCLES = 8;
    // several times the longest quiet stretch of a correct run
    localparam int STALL_LIMIT   = 4000;
    localparam logic [ACTION_W-1:0] ACT_UNUSED = 2'd3;

    logic                  i_clk;
    logic                  i_rst_n;
    logic                  i_start;
    t_in_item              i_item;
    logic                  o_busy;
    logic                  o_valid;
    t_out_item             o_result;
    logic                  i_cfg_we;
    logic [CFG_IDX_W-1:0]  i_cfg_index;
    logic [CFG_DATA_W-1:0] i_cfg_data;

    // shadow copy of the block state
    logic [BYTE_W-1:0]   tile_shadow [TILE_MEM_BYTES_DEF];
    bit                  tile_written [TILE_MEM_BYTES_DEF];
    logic [COLOR_W-1:0]  palette_shadow [256];
    logic                mode8_shadow;
    logic [OFFSET_W-1:0] base_shadow;

    t_out_item expected_pixels[$];
    int        err_count;
    int        items_sent;
    int        sender_idle_pct;
    int        stall_cycles;

    tile_background_pixel_renderer_unit dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_start     (i_start),
        .i_item      (i_item),
        .o_busy      (o_busy),
        .o_valid     (o_valid),
        .o_result    (o_result),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data)
    );

    // clock
    initial i_clk = 1'b0;
    always #CLK_HALF i_clk = ~i_clk;

    // one line per mismatch
    task automatic flag_mismatch(input string msg);
        err_count++;
        $display("ERROR @%0t: %s", $time, msg);
    endtask

    function automatic t_in_item pack_request(input logic [ACTION_W-1:0] action,
                                              input logic [ADDR_W-1:0] address,
                                              input logic [DATA_W-1:0] data,
                                              input logic [ENTRY_W-1:0] entry);
        t_in_item it;
        it.action    = action;
        it.address   = address;
        it.data      = data;
        it.map_entry = entry;
        return it;
    endfunction

    // tile memory address of byte k of a character, wrapping at 64K
    function automatic logic [OFFSET_W-1:0] char_byte_addr(input logic [CHAR_FIELD_W-1:0] chr,
                                                           input int k);
        if (mode8_shadow) return base_shadow + OFFSET_W'({chr, 6'b0}) + OFFSET_W'(k);
        return base_shadow + OFFSET_W'({chr, 5'b0}) + OFFSET_W'(k);
    endfunction

    // expected 64 pixels of one map entry in raster order
    function automatic void predict_tile_pixels(input logic [ENTRY_W-1:0] entry);
        logic [CHAR_FIELD_W-1:0] chr;
        logic [COORD_W-1:0]      sx;
        logic [COORD_W-1:0]      sy;
        logic [PIX_IDX_W-1:0]    pix;
        logic [BYTE_W-1:0]       tbyte;
        logic [NIB_W-1:0]        nib;
        logic [PAL_IDX_W-1:0]    pal_idx;
        t_out_item               px;
        chr = entry[CHAR_FIELD_W-1:0];
        for (int y = 0; y < 8; y++) begin
            for (int x = 0; x < 8; x++) begin
                sx  = entry[HFLIP_POS] ? COORD_W'(7 - x) : COORD_W'(x);
                sy  = entry[VFLIP_POS] ? COORD_W'(7 - y) : COORD_W'(y);
                pix = {sy, sx};
                if (mode8_shadow) begin
                    pal_idx = tile_shadow[char_byte_addr(chr, pix)];
                end else begin
                    tbyte   = tile_shadow[char_byte_addr(chr, pix >> 1)];
                    nib     = sx[0] ? tbyte[7:4] : tbyte[3:0];
                    pal_idx = {entry[ENTRY_W-1:BANK_LSB], nib};
                end
                px.pixel_x = COORD_W'(x);
                px.pixel_y = COORD_W'(y);
                px.color   = palette_shadow[pal_idx];
                px.last    = ({COORD_W'(y), COORD_W'(x)} == LAST_PIX);
                expected_pixels.push_back(px);
            end
        end
    endfunction

    // shadow update for an accepted transaction
    function automatic void apply_request(input t_in_item it);
        case (it.action)
            ACT_TILE_WR: begin
                tile_shadow[it.address]  = it.data[BYTE_W-1:0];
                tile_written[it.address] = 1'b1;
            end
            ACT_PAL_WR: palette_shadow[it.address[PAL_IDX_W-1:0]] = it.data;
            ACT_DRAW:   predict_tile_pixels(it.map_entry);
            default: ;
        endcase
    endfunction

    // send one transaction, with random sender gaps ahead of it
    task automatic send_request(input t_in_item it);
        while (sender_idle_pct > 0 && $urandom_range(99) < sender_idle_pct) begin
            i_start <= 1'b0;
            @(posedge i_clk);
        end
        i_start <= 1'b1;
        i_item  <= it;
        do @(posedge i_clk); while (o_busy);
        apply_request(it);
        if (it.action != ACT_UNUSED) items_sent++;
    endtask

    // write any unwritten byte of the character, then draw it
    task automatic draw_tile(input logic [ENTRY_W-1:0] entry);
        logic [OFFSET_W-1:0] addr;
        int                  nbytes;
        nbytes = mode8_shadow ? 64 : 32;
        for (int k = 0; k < nbytes; k++) begin
            addr = char_byte_addr(entry[CHAR_FIELD_W-1:0], k);
            if (!tile_written[addr])
                send_request(pack_request(ACT_TILE_WR, addr, $urandom, 16'($urandom)));
        end
        send_request(pack_request(ACT_DRAW, 16'($urandom), $urandom, entry));
    endtask

    // drop start and let every pending pixel drain
    task automatic wait_idle();
        i_start <= 1'b0;
        while (expected_pixels.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] value);
        wait_idle();
        i_cfg_we    <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= value;
        @(posedge i_clk);
        i_cfg_we    <= 1'b0;
        if (idx == CFG_COLOR_MODE) mode8_shadow = value[0];
        else base_shadow = value;
    endtask

    task automatic configure(input logic mode8, input logic [OFFSET_W-1:0] base);
        write_reg(CFG_COLOR_MODE, {15'($urandom), mode8});
        write_reg(CFG_CHAR_BASE, base);
    endtask

    // mostly a small set of characters so tile data gets reused
    function automatic logic [ENTRY_W-1:0] pick_entry();
        logic [CHAR_FIELD_W-1:0] chr;
        case ($urandom_range(9))
            0: chr = '0;
            1: chr = 10'd1;
            2: chr = 10'd7;
            3: chr = 10'd128;
            4: chr = 10'd511;
            5: chr = 10'd512;
            6: chr = 10'd1022;
            7: chr = '1;
            default: chr = 10'($urandom);
        endcase
        return {4'($urandom), 2'($urandom), chr};
    endfunction

    // all 256 palette entries, high address bits random
    task automatic test_palette_load();
        logic [COLOR_W-1:0] color;
        sender_idle_pct = 0;
        for (int i = 0; i < 256; i++) begin
            color = (i == 0) ? '0 : (i == 255) ? '1 : COLOR_W'($urandom);
            send_request(pack_request(ACT_PAL_WR, {8'($urandom), 8'(i)}, color,
                                      16'($urandom)));
        end
    endtask

    // reset configuration: 4bpp at base 0, every flip, both bank extremes
    task automatic test_reset_config_flips();
        draw_tile(16'h0000);
        draw_tile(16'h0400);
        draw_tile(16'h0800);
        draw_tile(16'hFC00);
        draw_tile(16'h53FF);
    endtask

    // unused action must leave tile memory alone
    task automatic test_ignored_action();
        send_request(pack_request(ACT_UNUSED, 16'h0000, $urandom, 16'($urandom)));
        send_request(pack_request(ACT_UNUSED, 16'($urandom), $urandom, 16'($urandom)));
        draw_tile(16'h0000);
    endtask

    // character data running past the top of tile memory
    task automatic test_address_wrap();
        configure(1'b1, 16'hFFFF);
        draw_tile(16'h03FF);
        draw_tile(16'hFFFF);
        configure(1'b0, 16'hFFFF);
        draw_tile(16'hF3FF);
        draw_tile(16'h0FFF);
    endtask

    // random mix of writes, draws and ignored transactions
    task automatic test_random_mix(input int n_items, input logic mode8,
                                   input logic [OFFSET_W-1:0] base, input int idle_pct);
        int first;
        int sel;
        configure(mode8, base);
        sender_idle_pct = idle_pct;
        first = items_sent;
        while (items_sent - first < n_items) begin
            sel = $urandom_range(99);
            if (sel < 45) draw_tile(pick_entry());
            else if (sel < 70)
                send_request(pack_request(ACT_TILE_WR, 16'($urandom), $urandom,
                                          16'($urandom)));
            else if (sel < 92)
                send_request(pack_request(ACT_PAL_WR, 16'($urandom), $urandom,
                                          16'($urandom)));
            else
                send_request(pack_request(ACT_UNUSED, 16'($urandom), $urandom,
                                          16'($urandom)));
        end
    endtask

    // compare each result transaction with the oldest expected pixel
    always @(posedge i_clk) begin : check_pixels
        t_out_item want;
        if (i_rst_n && o_valid) begin
            if (expected_pixels.size() == 0) begin
                flag_mismatch($sformatf("unexpected pixel x=%0d y=%0d color=%h",
                                        o_result.pixel_x, o_result.pixel_y, o_result.color));
            end else begin
                want = expected_pixels.pop_front();
                if (o_result.pixel_x !== want.pixel_x)
                    flag_mismatch($sformatf("pixel_x got %0d want %0d",
                                            o_result.pixel_x, want.pixel_x));
                if (o_result.pixel_y !== want.pixel_y)
                    flag_mismatch($sformatf("pixel_y got %0d want %0d",
                                            o_result.pixel_y, want.pixel_y));
                if (o_result.color !== want.color)
                    flag_mismatch($sformatf("color at (%0d,%0d) got %h want %h",
                                            want.pixel_x, want.pixel_y,
                                            o_result.color, want.color));
                if (o_result.last !== want.last)
                    flag_mismatch($sformatf("last at (%0d,%0d) got %b want %b",
                                            want.pixel_x, want.pixel_y,
                                            o_result.last, want.last));
            end
        end
    end

    // watchdog on cycles with no transaction in either direction
    always @(posedge i_clk) begin
        if ((i_start && !o_busy) || o_valid) stall_cycles <= 0;
        else stall_cycles <= stall_cycles + 1;
        if (stall_cycles >= STALL_LIMIT) begin
            $display("** tile_background_pixel_renderer_unit: FAILED **");
            $finish;
        end
    end

    initial begin
        i_rst_n     <= 1'b0;
        i_start     <= 1'b0;
        i_item      <= '0;
        i_cfg_we    <= 1'b0;
        i_cfg_index <= '0;
        i_cfg_data  <= '0;
        mode8_shadow = 1'b0;
        base_shadow  = '0;
        repeat (RESET_CYCLES) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_palette_load();
        test_reset_config_flips();
        test_ignored_action();
        test_address_wrap();
        test_random_mix(40, 1'b0, 16'h0000, 0);
        test_random_mix(40, 1'b1, 16'hFFFF, 77);
        test_random_mix(40, 1'b0, 16'hFFF0, 36);
        test_random_mix(40, 1'b1, 16'h0000, 0);
        test_random_mix(40, 1'($urandom), 16'($urandom), 77);

        wait_idle();
        if (err_count == 0) begin
            $display("** tile_background_pixel_renderer_unit: PASSED **");
        end else begin
            $display("** tile_background_pixel_renderer_unit: FAILED **");
        end
        $finish;
    end

endmodule
